// ----- hdl/lped_pkg.sv -----
`timescale 1ns / 1ps
package lped_pkg;

  // Fixed field widths of the pixel and feature transactions
  localparam int POS_W  = 12;
  localparam int CHAN_W = 8;
  localparam int FEAT_W = 20;

  // Datapath widths
  localparam int TAPS   = 5;
  localparam int SUM_W  = 10;  // r+g+b up to 765
  localparam int LAP_W  = 13;  // signed Laplacian, |L| <= 3060
  localparam int MAG_W  = 12;  // |L|
  localparam int DEN_W  = 13;  // |a|+|b|
  localparam int DIFF_W = 12;  // signed left/right difference, |d| <= 1530
  localparam int SQ_W   = 22;  // d*d
  localparam int THR_W  = 23;
  localparam int FILL_W = 3;

  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(21600);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);

  // Parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH    = 4;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_EDGE_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              line_start;
  } pixel_t;

  typedef struct packed {
    logic [FEAT_W-1:0] feat_x;
    logic [FEAT_W-1:0] feat_y;
    logic              exact_hit;
  } feature_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_DONE
  } back_state_t;

endpackage

// ----- hdl/lped_front.sv -----
`timescale 1ns / 1ps
module lped_front import lped_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pixel_t                 pixel,
  input  logic                   accept,
  input  logic                   advance,
  input  logic [THR_W-1:0]       edge_threshold,
  output logic                   job_push,
  output logic [2*MAG_W+4*COORD_BITS:0] job
);

  localparam int PosW = 2 * COORD_BITS;

  // Window
  logic [SUM_W-1:0]  sum_win [TAPS];
  logic [PosW-1:0]   pos_win [TAPS];
  logic [FILL_W-1:0] fill_count;
  logic              w_valid;
  logic              w_lap;
  logic              w_cmp;

  // Classify stage
  logic signed [LAP_W-1:0]  prev_lap;
  logic                     b_valid;
  logic                     b_exact;
  logic signed [LAP_W-1:0]  b_a;
  logic signed [LAP_W-1:0]  b_b;
  logic signed [DIFF_W-1:0] b_dl;
  logic signed [DIFF_W-1:0] b_dr;
  logic [COORD_BITS-1:0]    b_x0, b_y0, b_x1, b_y1;

  // Contrast stage
  logic                  c_valid;
  logic                  c_exact;
  logic [SQ_W-1:0]       c_sql;
  logic [SQ_W-1:0]       c_sqr;
  logic [MAG_W-1:0]      c_ua;
  logic [MAG_W-1:0]      c_ub;
  logic [COORD_BITS-1:0] c_x0, c_y0, c_x1, c_y1;

  logic [FILL_W-1:0]        k;
  logic [SUM_W-1:0]         s_in;
  logic signed [LAP_W-1:0]  s0, s1, s2, s3, s4;
  logic signed [LAP_W-1:0]  lap;
  logic signed [DIFF_W-1:0] dl, dr;
  logic                     is_exact;
  logic                     is_cross;
  logic signed [2*DIFF_W-1:0] pl, pr;
  logic [LAP_W-1:0]         abs_a, abs_b;
  logic [THR_W-1:0]         contrast;

  assign k    = pixel.line_start ? '0 : fill_count;
  assign s_in = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      w_valid    <= 1'b0;
    end else if (advance) begin
      w_valid <= accept;
      if (accept) begin
        fill_count <= (k < FILL_FULL) ? k + 1'b1 : FILL_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        sum_win[i] <= sum_win[i+1];
        pos_win[i] <= pos_win[i+1];
      end
      sum_win[TAPS-1] <= s_in;
      pos_win[TAPS-1] <= {COORD_BITS'(pixel.pos_y), COORD_BITS'(pixel.pos_x)};
      w_lap <= (k >= FILL_W'(TAPS - 1));
      w_cmp <= (k >= FILL_FULL);
    end
  end

  assign s0  = $signed(LAP_W'(sum_win[0]));
  assign s1  = $signed(LAP_W'(sum_win[1]));
  assign s2  = $signed(LAP_W'(sum_win[2]));
  assign s3  = $signed(LAP_W'(sum_win[3]));
  assign s4  = $signed(LAP_W'(sum_win[4]));
  assign lap = (s2 <<< 2) - s0 - s1 - s3 - s4;
  assign dl  = DIFF_W'((s2 <<< 1) - s0 - s1);
  assign dr  = DIFF_W'(s3 + s4 - (s2 <<< 1));

  assign is_exact = (prev_lap != '0) && (lap == '0);
  assign is_cross = ((prev_lap < 0) && (lap > 0)) || ((prev_lap > 0) && (lap < 0));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lap <= '0;
      b_valid  <= 1'b0;
    end else if (advance) begin
      b_valid <= w_valid && w_cmp && (is_exact || is_cross);
      if (w_valid && w_lap) begin
        prev_lap <= lap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_exact <= is_exact;
      b_a     <= prev_lap;
      b_b     <= lap;
      b_dl    <= dl;
      b_dr    <= dr;
      b_x1    <= pos_win[2][COORD_BITS-1:0];
      b_y1    <= pos_win[2][PosW-1:COORD_BITS];
      // an exact hit interpolates from the centre to itself
      b_x0    <= is_exact ? pos_win[2][COORD_BITS-1:0] : pos_win[1][COORD_BITS-1:0];
      b_y0    <= is_exact ? pos_win[2][PosW-1:COORD_BITS] : pos_win[1][PosW-1:COORD_BITS];
    end
  end

  assign pl    = b_dl * b_dl;
  assign pr    = b_dr * b_dr;
  assign abs_a = (b_a < 0) ? LAP_W'(-b_a) : LAP_W'(b_a);
  assign abs_b = (b_b < 0) ? LAP_W'(-b_b) : LAP_W'(b_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_exact <= b_exact;
      c_sql   <= pl[SQ_W-1:0];
      c_sqr   <= pr[SQ_W-1:0];
      c_ua    <= abs_a[MAG_W-1:0];
      c_ub    <= abs_b[MAG_W-1:0];
      c_x0    <= b_x0;
      c_y0    <= b_y0;
      c_x1    <= b_x1;
      c_y1    <= b_y1;
    end
  end

  assign contrast = THR_W'(c_sql) + THR_W'(c_sqr);
  assign job_push = advance && c_valid && (contrast >= edge_threshold);
  assign job      = {c_exact, c_ua, c_ub, c_x0, c_y0, c_x1, c_y1};

endmodule

// ----- hdl/lped_queue.sv -----
`timescale 1ns / 1ps
module lped_queue import lped_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output q_status_t        status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/lped_back.sv -----
`timescale 1ns / 1ps
module lped_back import lped_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  q_status_t                     q_status,
  input  logic [2*MAG_W+4*COORD_BITS:0] job,
  output logic                          job_pop,
  output feature_t                      feature,
  output logic                          empty,
  input  logic                          pop
);

  localparam int CntW = $clog2(FRAC_BITS);

  back_state_t state, state_next;

  logic                  j_exact;
  logic [MAG_W-1:0]      j_ua, j_ub;
  logic [COORD_BITS-1:0] j_x0, j_y0, j_x1, j_y1;

  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic [FRAC_BITS-1:0]  quot;
  logic [CntW-1:0]       cnt;
  logic                  exact;
  logic [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [FEAT_W-1:0]     prod_x, prod_y;
  logic                  out_valid;

  logic                  out_free;
  logic                  div_step;
  logic                  load_out;
  logic [DEN_W:0]        shifted;
  logic                  ge;
  logic signed [COORD_BITS:0] dx, dy;
  logic [FEAT_W-1:0]     tq_w;
  logic [COORD_BITS+FRAC_BITS-1:0] base_x, base_y;

  assign {j_exact, j_ua, j_ub, j_x0, j_y0, j_x1, j_y1} = job;
  assign out_free = !out_valid || pop;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = j_exact ? BK_MUL : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt == CntW'(FRAC_BITS - 1)) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL:  state_next = BK_DONE;
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: job_pop  = !q_status.empty;
      BK_DIV:  div_step = 1'b1;
      BK_MUL:  ;
      BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Restoring divider: one quotient bit per cycle
  assign shifted = {rem, 1'b0};
  assign ge      = (shifted >= {1'b0, den});

  assign dx     = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign tq_w   = FEAT_W'(quot);
  assign base_x = {x0, {FRAC_BITS{1'b0}}};
  assign base_y = {y0, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (job_pop) begin
      exact <= j_exact;
      rem   <= DEN_W'(j_ua);
      den   <= DEN_W'(j_ua) + DEN_W'(j_ub);
      quot  <= '0;
      cnt   <= '0;
      x0    <= j_x0;
      y0    <= j_y0;
      x1    <= j_x1;
      y1    <= j_y1;
    end
    if (div_step) begin
      rem  <= ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      quot <= {quot[FRAC_BITS-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
    if (state == BK_MUL) begin
      // only the low feature bits matter, so work modulo 2^FEAT_W
      prod_x <= tq_w * FEAT_W'(dx);
      prod_y <= tq_w * FEAT_W'(dy);
    end
    if (load_out) begin
      feature.feat_x    <= FEAT_W'(base_x) + prod_x;
      feature.feat_y    <= FEAT_W'(base_y) + prod_y;
      feature.exact_hit <= exact;
    end
  end

  assign empty = !out_valid;

endmodule

// ----- hdl/line_profile_edge_detector.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// pixel     in         push / full               pixel_t (rgb, position, line_start)
// feature   out        pop / empty               feature_t (feat_x, feat_y, exact_hit)
// config    in         psel/penable/pwrite/pready edge_threshold at byte address 0
//
// The front takes one pixel per cycle while the job queue has room; a pixel that
// yields no feature costs nothing further. The back takes an exact hit from idle
// to multiply and done; a crossing first runs the one-bit-per-cycle restoring divider.
// A pixel passes the window, classify and contrast registers, then queue and back.
// Synchronous reset clears control state, loads THR_RESET; window contents are not
// cleared. A full queue holds the whole front, and a result not taken holds the back.
module line_profile_edge_detector import lped_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel transactions
  input  logic                  push,
  output logic                  full,
  input  pixel_t                pixel,
  // feature transactions
  input  logic                  pop,
  output logic                  empty,
  output feature_t              feature,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int JobW = 2 * MAG_W + 4 * COORD_BITS + 1;

  logic [THR_W-1:0] edge_threshold;
  logic             reg_index;
  logic             advance;
  logic             accept;
  logic             job_push;
  logic             job_pop;
  logic [JobW-1:0]  job_in;
  logic [JobW-1:0]  job_head;
  q_status_t        q_status;

  // Configuration: one register, always ready
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign prdata    = (reg_index == REG_EDGE_THRESHOLD) ?
                     APB_DATA_W'(edge_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_index == REG_EDGE_THRESHOLD)) begin
      edge_threshold <= pwdata[THR_W-1:0];
    end
  end

  // Advance the whole front together; hold it while the queue is full
  assign advance = !q_status.full;
  assign full    = !advance;
  assign accept  = push && advance;

  lped_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .pixel         (pixel),
    .accept        (accept),
    .advance       (advance),
    .edge_threshold(edge_threshold),
    .job_push      (job_push),
    .job           (job_in)
  );

  lped_queue #(
    .WIDTH(JobW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_data(job_in),
    .pop      (job_pop),
    .head     (job_head),
    .status   (q_status)
  );

  lped_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_status(q_status),
    .job     (job_head),
    .job_pop (job_pop),
    .feature (feature),
    .empty   (empty),
    .pop     (pop)
  );

  // The job queue can never report full and empty at once
  assert property (@(posedge clk) disable iff (rst) !(q_status.full && q_status.empty))
    else $error("job queue full and empty together");

  // No feature is offered right after reset
  assert property (@(posedge clk) rst |=> empty)
    else $error("feature offered after reset");

  // An exact hit lies on a sample, so its fraction bits are zero
  assert property (@(posedge clk) disable iff (rst)
                   (!empty && feature.exact_hit) |->
                   (feature.feat_x[FRAC_BITS-1:0] == '0) &&
                   (feature.feat_y[FRAC_BITS-1:0] == '0))
    else $error("exact hit with nonzero fraction");

  // A job is only pushed into a queue with room
  assert property (@(posedge clk) disable iff (rst) job_push |-> !q_status.full)
    else $error("job pushed into full queue");

endmodule

// ----- verif/line_profile_edge_detector_test.sv -----
`timescale 1ns / 1ps
module line_profile_edge_detector_test;
  import lped_pkg::*;

  // Largest legal threshold: both contrast terms at 2*765.
  localparam int THR_MAX = 4681800;
  // A pixel passes the front, the queue and the back's divider; pad well past that.
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT = 17;
  localparam logic [APB_ADDR_W-1:0] THR_ADDR   = APB_ADDR_W'(4 * REG_EDGE_THRESHOLD);
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4);

  typedef enum {
    ROW_NONE,   // no feature may come out of this pixel
    ROW_FEAT,   // feature typed into the row
    ROW_MODEL,  // feature, if any, comes from the predictor
    ROW_CFG     // register write between pixel runs
  } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    pixel_t                  px;
    feature_t                feat;
    logic [APB_ADDR_W-1:0]   addr;
    logic [APB_DATA_W-1:0]   wdata;
  } plan_row_t;

  logic                  clk;
  logic                  rst     = 1'b1;
  logic                  push    = 1'b0;
  logic                  full;
  pixel_t                pixel   = '0;
  logic                  pop     = 1'b0;
  logic                  empty;
  feature_t              feature;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the detector state, updated once per accepted pixel.
  logic [SUM_W-1:0]        sum_win [TAPS];
  logic [2*POS_W-1:0]      pos_win [TAPS];
  logic signed [LAP_W-1:0] last_lap   = '0;
  logic [FILL_W-1:0]       fill_level = '0;
  logic [THR_W-1:0]        edge_thr   = THR_RESET;

  feature_t  pending_features[$];
  plan_row_t plan[$];

  bit steady = 1'b0;  // when set, neither side idles
  int mismatches = 0;
  int pixels_sent = 0;
  int exact_checked = 0;
  int crossing_checked = 0;
  int settings_used = 0;

  line_profile_edge_detector u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .pop     (pop),
    .empty   (empty),
    .feature (feature),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a transaction never completes.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Window the pixel, form the Laplacian at the centre tap and decide whether
  // a feature comes out. Returns 1 with the feature in f when one does.
  function automatic bit predict_feature(input pixel_t px, output feature_t f);
    int s[TAPS];
    int i, k, lap, a, b, ua, ub, tq, x0, y0, x1, y1;
    longint dl, dr, contrast;
    bit exact_zero, sign_flip, hit;
    hit = 1'b0;
    f = '0;
    if (px.line_start) fill_level = '0;
    k = fill_level;
    for (i = 0; i < TAPS - 1; i++) begin
      sum_win[i] = sum_win[i + 1];
      pos_win[i] = pos_win[i + 1];
    end
    sum_win[TAPS-1] = SUM_W'(px.red) + SUM_W'(px.green) + SUM_W'(px.blue);
    pos_win[TAPS-1] = {px.pos_y, px.pos_x};
    if (k >= TAPS - 1) begin
      for (i = 0; i < TAPS; i++) s[i] = int'(sum_win[i]);
      lap = 4 * s[2] - s[0] - s[1] - s[3] - s[4];
      if (k >= TAPS) begin
        a = int'(last_lap);
        b = lap;
        exact_zero = (a != 0) && (b == 0);
        sign_flip  = (a < 0 && b > 0) || (a > 0 && b < 0);
        if (exact_zero || sign_flip) begin
          dl = 2 * s[2] - s[0] - s[1];
          dr = s[3] + s[4] - 2 * s[2];
          contrast = dl * dl + dr * dr;
          if (contrast >= longint'(edge_thr)) begin
            x1 = int'(pos_win[2][POS_W-1:0]);
            y1 = int'(pos_win[2][2*POS_W-1:POS_W]);
            if (exact_zero) begin
              f.feat_x    = FEAT_W'(x1 << FRAC_BITS_DEF);
              f.feat_y    = FEAT_W'(y1 << FRAC_BITS_DEF);
              f.exact_hit = 1'b1;
            end else begin
              x0 = int'(pos_win[1][POS_W-1:0]);
              y0 = int'(pos_win[1][2*POS_W-1:POS_W]);
              ua = (a < 0) ? -a : a;
              ub = (b < 0) ? -b : b;
              // Truncated fraction of the way from the previous tap to the centre.
              tq = (ua << FRAC_BITS_DEF) / (ua + ub);
              f.feat_x    = FEAT_W'((x0 << FRAC_BITS_DEF) + tq * (x1 - x0));
              f.feat_y    = FEAT_W'((y0 << FRAC_BITS_DEF) + tq * (y1 - y0));
              f.exact_hit = 1'b0;
            end
            hit = 1'b1;
          end
        end
      end
      last_lap = LAP_W'(lap);
    end
    fill_level = (k < TAPS) ? FILL_W'(k + 1) : FILL_FULL;
    return hit;
  endfunction

  function automatic void add_pixel(input row_kind_t kind, input int r, input int g,
                                    input int b, input int x, input int y, input bit ls,
                                    input int fx = 0, input int fy = 0,
                                    input bit ex = 1'b0);
    plan_row_t row;
    row.kind            = kind;
    row.px.red          = CHAN_W'(r);
    row.px.green        = CHAN_W'(g);
    row.px.blue         = CHAN_W'(b);
    row.px.pos_x        = POS_W'(x);
    row.px.pos_y        = POS_W'(y);
    row.px.line_start   = ls;
    row.feat.feat_x     = FEAT_W'(fx);
    row.feat.feat_y     = FEAT_W'(fy);
    row.feat.exact_hit  = ex;
    row.addr            = '0;
    row.wdata           = '0;
    plan = {plan, row};
  endfunction

  function automatic void add_cfg(input logic [APB_ADDR_W-1:0] addr, input int data);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.px    = '0;
    row.feat  = '0;
    row.addr  = addr;
    row.wdata = APB_DATA_W'(data);
    plan = {plan, row};
  endfunction

  // Offer one pixel transaction, hold it until taken, then book its expectation.
  task automatic feed_pixel(input pixel_t px, input row_kind_t kind, input feature_t typed);
    feature_t predicted;
    bit produces;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (full);
    produces = predict_feature(px, predicted);
    pixels_sent++;
    case (kind)
      ROW_MODEL: if (produces) pending_features = {pending_features, predicted};
      ROW_FEAT:  pending_features = {pending_features, typed};
      default: ;
    endcase
  endtask

  // One APB transfer: setup, access, then bus idle.
  // Reads are compared with the shadow threshold.
  task automatic apb_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (is_write) begin
      // Writes to any other index fall on the floor.
      if ((addr >> 2) == REG_EDGE_THRESHOLD) edge_thr = data[THR_W-1:0];
    end else if (prdata !== APB_DATA_W'(edge_thr)) begin
      $display("%0t threshold readback mismatch: expected %0d, got %0d",
               $time, edge_thr, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop push and wait until the detector has gone quiet.
  task automatic settle();
    push <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
    settle();
    apb_access(1'b1, addr, data);
    apb_access(1'b0, THR_ADDR, '0);
    settings_used++;
  endtask

  // Random scan lines. Most are well formed: line_start on the first pixel,
  // positions stepping like a rasterized line, and either noisy plateaus with
  // steps or gray ramps that clip (ramps give exact zeros). The rest is noise
  // with stray line_start marks.
  task automatic run_random_lines(input int n_items);
    int sent, len, style, i, base_r, base_g, base_b, lvl, slope, v, x, y, dx, dy;
    pixel_t px;
    sent = 0;
    while (sent < n_items) begin
      len    = $urandom_range(1, 40);
      style  = $urandom_range(0, 99);
      x      = $urandom_range(0, 4095);
      y      = $urandom_range(0, 4095);
      dx     = $urandom_range(0, 2) - 1;
      dy     = $urandom_range(0, 2) - 1;
      base_r = $urandom_range(0, 255);
      base_g = $urandom_range(0, 255);
      base_b = $urandom_range(0, 255);
      lvl    = $urandom_range(0, 255);
      slope  = $urandom_range(0, 12) - 6;
      for (i = 0; i < len && sent < n_items; i++) begin
        if (style < 75) begin
          px.line_start = (i == 0);
          px.pos_x      = POS_W'(x);
          px.pos_y      = POS_W'(y);
          if (style < 50) begin
            if ($urandom_range(0, 99) < 15) begin
              base_r = $urandom_range(0, 255);
              base_g = $urandom_range(0, 255);
              base_b = $urandom_range(0, 255);
            end
            px.red   = CHAN_W'(base_r) ^ CHAN_W'($urandom_range(0, 3));
            px.green = CHAN_W'(base_g) ^ CHAN_W'($urandom_range(0, 3));
            px.blue  = CHAN_W'(base_b) ^ CHAN_W'($urandom_range(0, 3));
          end else begin
            v = lvl + slope * i;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            px.red   = CHAN_W'(v);
            px.green = CHAN_W'(v);
            px.blue  = CHAN_W'(v);
          end
        end else begin
          px.red        = CHAN_W'($urandom);
          px.green      = CHAN_W'($urandom);
          px.blue       = CHAN_W'($urandom);
          px.pos_x      = POS_W'($urandom);
          px.pos_y      = POS_W'($urandom);
          px.line_start = ($urandom_range(0, 7) == 0);
        end
        x = (x + dx) & 12'hFFF;
        y = (y + dy) & 12'hFFF;
        feed_pixel(px, ROW_MODEL, '0);
        sent++;
      end
    end
  endtask

  // Result side: stall at random, never while the steady stretch runs.
  always @(posedge clk) begin
    pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare every feature transaction against the oldest expectation.
  always @(posedge clk) begin
    feature_t want;
    if (!rst && pop && !empty) begin
      if (pending_features.size() == 0) begin
        $display("%0t unexpected feature: expected none, got x=%0d y=%0d exact=%0b",
                 $time, feature.feat_x, feature.feat_y, feature.exact_hit);
        mismatches++;
      end else begin
        want = pending_features.pop_front();
        if (feature.feat_x !== want.feat_x) begin
          $display("%0t feat_x mismatch: expected %0d, got %0d",
                   $time, want.feat_x, feature.feat_x);
          mismatches++;
        end
        if (feature.feat_y !== want.feat_y) begin
          $display("%0t feat_y mismatch: expected %0d, got %0d",
                   $time, want.feat_y, feature.feat_y);
          mismatches++;
        end
        if (feature.exact_hit !== want.exact_hit) begin
          $display("%0t exact_hit mismatch: expected %0b, got %0b",
                   $time, want.exact_hit, feature.exact_hit);
          mismatches++;
        end
        if (want.exact_hit) exact_checked++;
        else crossing_checked++;
      end
    end
  end

  initial begin
    int phase;
    logic [APB_DATA_W-1:0] thr_value;

    // Directed plan, reset threshold first.
    // Step line: S goes 0,0,0,255,510,510. L at the fourth pixel is exactly zero
    // after a negative L, so the sixth pixel reports the fourth's position.
    add_pixel(ROW_NONE, 0, 0, 0, 0, 0, 1'b1);
    add_pixel(ROW_NONE, 0, 0, 0, 1, 0, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 2, 0, 1'b0);
    add_pixel(ROW_NONE, 85, 85, 85, 4095, 4095, 1'b0);
    add_pixel(ROW_NONE, 170, 170, 170, 3, 1, 1'b0);
    add_pixel(ROW_FEAT, 170, 170, 170, 4, 2, 1'b0, 1048320, 1048320, 1'b1);
    // Previous L was zero, new one positive: nothing comes out.
    add_pixel(ROW_NONE, 255, 255, 255, 5, 3, 1'b0);
    // New line mid-stream. Flat start gives zero then zero, then a lone bump:
    // zero then nonzero, equal signs, and finally a crossing below threshold.
    add_pixel(ROW_NONE, 0, 0, 0, 100, 200, 1'b1);
    add_pixel(ROW_NONE, 0, 0, 0, 101, 200, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 102, 200, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 103, 200, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 104, 200, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 105, 200, 1'b0);
    add_pixel(ROW_NONE, 1, 1, 1, 106, 200, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 107, 200, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 108, 200, 1'b0);
    // Single full channels push the contrast over the threshold.
    add_pixel(ROW_MODEL, 255, 0, 0, 109, 200, 1'b0);
    add_pixel(ROW_MODEL, 0, 255, 0, 110, 200, 1'b0);
    add_pixel(ROW_MODEL, 0, 0, 255, 111, 200, 1'b0);
    // Highest threshold, met exactly by a white spike on black. The crossing
    // runs toward a smaller column and a larger row.
    add_cfg(THR_ADDR, THR_MAX);
    add_pixel(ROW_NONE, 0, 0, 0, 10, 10, 1'b1);
    add_pixel(ROW_NONE, 0, 0, 0, 11, 11, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 4095, 0, 1'b0);
    add_pixel(ROW_NONE, 255, 255, 255, 4094, 1, 1'b0);
    add_pixel(ROW_NONE, 0, 0, 0, 4093, 2, 1'b0);
    add_pixel(ROW_MODEL, 0, 0, 0, 4092, 3, 1'b0);
    // A write to an unmapped index must leave the threshold alone.
    add_cfg(SPARE_ADDR, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Check the reset value before anything is written.
    apb_access(1'b0, THR_ADDR, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) reconfigure(plan[i].addr, plan[i].wdata);
      else feed_pixel(plan[i].px, plan[i].kind, plan[i].feat);
    end

    // Random phases, each after its own threshold write. Phase 3 runs with no idling
    // on either side so the job queue fills.
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       thr_value = APB_DATA_W'(THR_RESET);
        1:       thr_value = '0;
        2:       thr_value = APB_DATA_W'($urandom_range(0, THR_MAX));
        3, 5:    thr_value = APB_DATA_W'($urandom_range(0, 60000));
        4:       thr_value = APB_DATA_W'(THR_MAX);
        default: thr_value = APB_DATA_W'(THR_RESET);
      endcase
      reconfigure(THR_ADDR, thr_value);
      steady = (phase == 3);
      run_random_lines(115);
      steady = 1'b0;
    end

    settle();
    $display("Sent %0d pixels under %0d register settings", pixels_sent, settings_used);
    $display("Checked %0d exact and %0d interpolated features",
             exact_checked, crossing_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lped_pkg.sv
hdl/lped_front.sv
hdl/lped_queue.sv
hdl/lped_back.sv
hdl/line_profile_edge_detector.sv
verif/line_profile_edge_detector_test.sv
